>>> hdl/abrf_pkg.sv
// Shared types, codes and vector tables for the banked register file.
`default_nettype none

package abrf_pkg;

    // Word and field widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned MODE_W  = 5;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned NREGS   = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_READ_REG   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_REG  = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_CPSR = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE_SPSR = 3'd3;
    localparam logic [OP_W-1:0] OP_EXCEPTION  = 3'd4;

    // Exception kinds
    localparam logic [KIND_W-1:0] EXC_RESET = 3'd0;
    localparam logic [KIND_W-1:0] EXC_UNDEF = 3'd1;
    localparam logic [KIND_W-1:0] EXC_SWI   = 3'd2;
    localparam logic [KIND_W-1:0] EXC_PABT  = 3'd3;
    localparam logic [KIND_W-1:0] EXC_DABT  = 3'd4;
    localparam logic [KIND_W-1:0] EXC_IRQ   = 3'd5;
    localparam logic [KIND_W-1:0] EXC_FIQ   = 3'd6;

    // Processor modes
    localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
    localparam logic [MODE_W-1:0] MODE_UND = 5'h1b;
    localparam logic [MODE_W-1:0] MODE_SYS = 5'h1f;

    // Status register bits
    localparam logic [WORD_W-1:0] PSR_T     = 32'h0000_0020;
    localparam logic [WORD_W-1:0] PSR_F     = 32'h0000_0040;
    localparam logic [WORD_W-1:0] PSR_I     = 32'h0000_0080;
    localparam logic [WORD_W-1:0] PSR_MODE  = 32'h0000_001f;
    localparam logic [WORD_W-1:0] CPSR_INIT = 32'h0000_0013;

    // Config register index (byte address bit 2)
    localparam logic CFG_VECTOR_BASE = 1'b0;

    // Register numbers with fixed roles
    localparam int unsigned R_BANK_LO = 8;
    localparam int unsigned R_SP      = 13;
    localparam int unsigned R_LR      = 14;
    localparam int unsigned R_PC      = 15;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [IDX_W-1:0]  reg_index;
        logic [WORD_W-1:0] write_value;
        logic [KIND_W-1:0] exception_kind;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [WORD_W-1:0] cpsr_value;
        logic [WORD_W-1:0] spsr_value;
    } result_t;

    // Vector offset per exception kind
    function automatic logic [WORD_W-1:0] vec_offset(input logic [KIND_W-1:0] kind);
        logic [WORD_W-1:0] off;
        case (kind)
            EXC_RESET: off = 32'h0000_0000;
            EXC_UNDEF: off = 32'h0000_0004;
            EXC_SWI:   off = 32'h0000_0008;
            EXC_PABT:  off = 32'h0000_000c;
            EXC_DABT:  off = 32'h0000_0010;
            EXC_IRQ:   off = 32'h0000_0018;
            EXC_FIQ:   off = 32'h0000_001c;
            default:   off = 32'h0000_0000;
        endcase
        return off;
    endfunction

    // Mode entered per exception kind
    function automatic logic [MODE_W-1:0] vec_mode(input logic [KIND_W-1:0] kind);
        logic [MODE_W-1:0] m;
        case (kind)
            EXC_RESET: m = MODE_SVC;
            EXC_UNDEF: m = MODE_UND;
            EXC_SWI:   m = MODE_SVC;
            EXC_PABT:  m = MODE_ABT;
            EXC_DABT:  m = MODE_ABT;
            EXC_IRQ:   m = MODE_IRQ;
            EXC_FIQ:   m = MODE_FIQ;
            default:   m = MODE_SVC;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hdl/abrf_state.sv
// Architectural state of the register file and its per-word update.
`default_nettype none

module abrf_state (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step,
    input  wire abrf_pkg::item_t           item,
    input  wire logic [31:0]               vector_base,
    output abrf_pkg::result_t              result
);
    import abrf_pkg::*;

    logic [WORD_W-1:0] vis_reg      [NREGS];
    logic [WORD_W-1:0] vis_next     [NREGS];
    logic [WORD_W-1:0] usr_sp_reg   [2];
    logic [WORD_W-1:0] usr_sp_next  [2];
    logic [WORD_W-1:0] usr_hi_reg   [5];
    logic [WORD_W-1:0] usr_hi_next  [5];
    logic [WORD_W-1:0] fiq_reg      [8];
    logic [WORD_W-1:0] fiq_next     [8];
    logic [WORD_W-1:0] irq_reg      [3];
    logic [WORD_W-1:0] irq_next     [3];
    logic [WORD_W-1:0] svc_reg      [3];
    logic [WORD_W-1:0] svc_next     [3];
    logic [WORD_W-1:0] abt_reg      [3];
    logic [WORD_W-1:0] abt_next     [3];
    logic [WORD_W-1:0] und_reg      [3];
    logic [WORD_W-1:0] und_next     [3];
    logic [WORD_W-1:0] cpsr_reg;
    logic [WORD_W-1:0] cpsr_next;
    logic [WORD_W-1:0] spsr_reg;
    logic [WORD_W-1:0] spsr_next;
    logic [MODE_W-1:0] banked_mode_reg;
    logic [MODE_W-1:0] banked_mode_next;

    logic              exc_take;
    logic [WORD_W-1:0] exc_cpsr;
    logic [WORD_W-1:0] exc_lr;
    logic              sw_en;
    logic [MODE_W-1:0] sw_mode;
    logic [MODE_W-1:0] prev_mode;

    // Exception entry terms, from the state before the word
    assign exc_take = step && (item.operation == OP_EXCEPTION)
                      && (item.exception_kind <= EXC_FIQ);
    assign exc_cpsr = (cpsr_reg & ~(PSR_T | PSR_MODE)) | PSR_I
                      | {{(WORD_W-MODE_W){1'b0}}, vec_mode(item.exception_kind)};
    assign exc_lr   = (item.exception_kind == EXC_RESET) ? '0 :
                      (item.exception_kind == EXC_DABT)  ? vis_reg[R_PC] + 32'd8 :
                                                           vis_reg[R_PC] + 32'd4;
    assign prev_mode = banked_mode_reg;

    // Next state: primary write, then bank swap, then exception writes
    always_comb begin
        vis_next         = vis_reg;
        usr_sp_next      = usr_sp_reg;
        usr_hi_next      = usr_hi_reg;
        fiq_next         = fiq_reg;
        irq_next         = irq_reg;
        svc_next         = svc_reg;
        abt_next         = abt_reg;
        und_next         = und_reg;
        cpsr_next        = cpsr_reg;
        spsr_next        = spsr_reg;
        banked_mode_next = banked_mode_reg;
        sw_en            = 1'b0;
        sw_mode          = banked_mode_reg;

        if (step) begin
            case (item.operation)
                OP_WRITE_REG: begin
                    vis_next[item.reg_index] = item.write_value;
                end
                OP_WRITE_CPSR: begin
                    cpsr_next = item.write_value;
                    sw_en     = 1'b1;
                    sw_mode   = item.write_value[MODE_W-1:0];
                end
                OP_WRITE_SPSR: begin
                    spsr_next = item.write_value;
                end
                OP_EXCEPTION: begin
                    if (exc_take) begin
                        cpsr_next = exc_cpsr;
                        sw_en     = 1'b1;
                        sw_mode   = vec_mode(item.exception_kind);
                    end
                end
                default: begin
                end
            endcase
        end

        if (sw_en && (sw_mode != prev_mode)) begin
            banked_mode_next = sw_mode;

            // save the outgoing mode's copies
            if (prev_mode == MODE_USR || prev_mode == MODE_SYS) begin
                usr_sp_next[0] = vis_next[R_SP];
                usr_sp_next[1] = vis_next[R_LR];
            end else if (prev_mode == MODE_FIQ) begin
                for (int i = 0; i < 7; i++) begin
                    fiq_next[i] = vis_next[R_BANK_LO + i];
                end
                fiq_next[7] = spsr_next;
                for (int i = 0; i < 5; i++) begin
                    vis_next[R_BANK_LO + i] = usr_hi_next[i];
                end
            end else begin
                case (prev_mode)
                    MODE_IRQ: irq_next = '{vis_next[R_SP], vis_next[R_LR], spsr_next};
                    MODE_SVC: svc_next = '{vis_next[R_SP], vis_next[R_LR], spsr_next};
                    MODE_ABT: abt_next = '{vis_next[R_SP], vis_next[R_LR], spsr_next};
                    MODE_UND: und_next = '{vis_next[R_SP], vis_next[R_LR], spsr_next};
                    default: begin
                    end
                endcase
            end

            // load the incoming mode's copies
            if (sw_mode == MODE_USR || sw_mode == MODE_SYS) begin
                vis_next[R_SP] = usr_sp_next[0];
                vis_next[R_LR] = usr_sp_next[1];
            end else if (sw_mode == MODE_FIQ) begin
                for (int i = 0; i < 5; i++) begin
                    usr_hi_next[i] = vis_next[R_BANK_LO + i];
                end
                for (int i = 0; i < 7; i++) begin
                    vis_next[R_BANK_LO + i] = fiq_next[i];
                end
                spsr_next = fiq_next[7];
            end else begin
                case (sw_mode)
                    MODE_IRQ: begin
                        vis_next[R_SP] = irq_next[0];
                        vis_next[R_LR] = irq_next[1];
                        spsr_next      = irq_next[2];
                    end
                    MODE_SVC: begin
                        vis_next[R_SP] = svc_next[0];
                        vis_next[R_LR] = svc_next[1];
                        spsr_next      = svc_next[2];
                    end
                    MODE_ABT: begin
                        vis_next[R_SP] = abt_next[0];
                        vis_next[R_LR] = abt_next[1];
                        spsr_next      = abt_next[2];
                    end
                    MODE_UND: begin
                        vis_next[R_SP] = und_next[0];
                        vis_next[R_LR] = und_next[1];
                        spsr_next      = und_next[2];
                    end
                    default: begin
                    end
                endcase
            end
        end

        // exception: SPSR, LR, PC and the F bit land after banking
        if (exc_take) begin
            spsr_next      = cpsr_reg;
            vis_next[R_LR] = exc_lr;
            vis_next[R_PC] = vector_base + vec_offset(item.exception_kind);
            if (item.exception_kind == EXC_RESET || item.exception_kind == EXC_FIQ) begin
                cpsr_next = cpsr_next | PSR_F;
            end
        end
    end

    // Result seen after this word
    assign result.read_data  = vis_next[item.reg_index];
    assign result.cpsr_value = cpsr_next;
    assign result.spsr_value = spsr_next;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_reg         <= '{default: '0};
            usr_sp_reg      <= '{default: '0};
            usr_hi_reg      <= '{default: '0};
            fiq_reg         <= '{default: '0};
            irq_reg         <= '{default: '0};
            svc_reg         <= '{default: '0};
            abt_reg         <= '{default: '0};
            und_reg         <= '{default: '0};
            cpsr_reg        <= CPSR_INIT;
            spsr_reg        <= '0;
            banked_mode_reg <= MODE_SVC;
        end else begin
            vis_reg         <= vis_next;
            usr_sp_reg      <= usr_sp_next;
            usr_hi_reg      <= usr_hi_next;
            fiq_reg         <= fiq_next;
            irq_reg         <= irq_next;
            svc_reg         <= svc_next;
            abt_reg         <= abt_next;
            und_reg         <= und_next;
            cpsr_reg        <= cpsr_next;
            spsr_reg        <= spsr_next;
            banked_mode_reg <= banked_mode_next;
        end
    end

    // bank tracking always follows the CPSR mode field
    assert property (@(posedge aclk) disable iff (!aresetn)
        banked_mode_reg == cpsr_reg[MODE_W-1:0])
        else $error("banked mode out of step with CPSR mode");

    // an SPSR write lands as written
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.operation == OP_WRITE_SPSR |=> spsr_reg == $past(item.write_value))
        else $error("SPSR write lost");

    // taking an exception always sets I and clears T
    assert property (@(posedge aclk) disable iff (!aresetn)
        exc_take |=> cpsr_reg[7] && !cpsr_reg[5])
        else $error("exception entry left wrong I or T bit");

endmodule

`default_nettype wire

>>> hdl/arm_banked_regfile_exception_entry.sv
// Top level: stream ports, config port and the two pipeline registers.
// Banked ARM-style register file with exception entry. Each input word
// carries one operation (read reg, write reg, write CPSR, write SPSR, take
// exception) and produces exactly one output word with the addressed register,
// CPSR and SPSR as they stand after the operation. A word is held in an input
// register, the whole state update including bank swaps is done combinationally,
// and the result goes to an output register: m_tvalid rises once the word has
// moved from the input register into the output register. One word is taken
// every clock while the output is not stalled. vector_base is written over
// the APB-style port at byte address 0 and should only be changed while no
// word is in flight. No clearing pass is needed after reset.
`default_nettype none

module arm_banked_regfile_exception_entry (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,   // [3:0] reg_index, [35:4] write_value, rest zero
    input  wire logic [5:0]   s_tuser,   // [2:0] operation, [5:3] exception_kind
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // [31:0] read_data, [63:32] cpsr_value,
                                         // [95:64] spsr_value
    // config port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import abrf_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic [31:0] vector_base_reg;
    result_t     step_result;
    item_t       s_item;
    logic        advance;
    logic        s_accept;

    // Unpack the input word
    assign s_item.operation      = s_tuser[2:0];
    assign s_item.exception_kind = s_tuser[5:3];
    assign s_item.reg_index      = s_tdata[3:0];
    assign s_item.write_value    = s_tdata[35:4];

    // Handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.spsr_value, out_data_reg.cpsr_value,
                       out_data_reg.read_data};

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
    end

    // State update
    abrf_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (in_item_reg),
        .vector_base (vector_base_reg),
        .result      (step_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    // Config register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_VECTOR_BASE) ? vector_base_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vector_base_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_VECTOR_BASE) begin
            vector_base_reg <= pwdata;
        end
    end

    // a processed word always shows up at the output next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("processed word not presented");

    // a held word stays put until it is processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending word lost or changed");

    // an accepted word always occupies the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted word dropped");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking stream testbench for the banked register file with exception entry.
module tb;
    import abrf_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PHASE_WORDS = 180;
    localparam logic [KIND_W-1:0] EXC_NONE = 3'd7;
    localparam logic [OP_W-1:0] OP_LAST = 3'd7;
    localparam logic [2:0] VBASE_ADDR = {CFG_VECTOR_BASE, 2'b00};
    localparam logic [MODE_W-1:0] MODE_LIST [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                                    MODE_ABT, MODE_UND, MODE_SYS};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // [3:0] reg_index, [35:4] write_value, rest zero
    logic [5:0]  s_tuser = '0;   // [2:0] operation, [5:3] exception_kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // [31:0] read_data, [63:32] cpsr_value, [95:64] spsr_value
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    arm_banked_regfile_exception_entry dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Pending words, expected results, error bookkeeping
    item_t       pending_items [$];
    result_t     due_results [$];
    item_t       word_on_bus;
    int unsigned err_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_hold = 0;
    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;

    // Predicted register file state
    logic [WORD_W-1:0] reg_view [NREGS];
    logic [WORD_W-1:0] usr_sp_lr [2];
    logic [WORD_W-1:0] usr_hi [5];
    logic [WORD_W-1:0] fiq_save [8];
    logic [WORD_W-1:0] mode_save [4][3];   // irq, svc, abt, und: sp, lr, spsr
    logic [WORD_W-1:0] cpsr_now;
    logic [WORD_W-1:0] spsr_now;
    logic [WORD_W-1:0] vec_base;
    logic [MODE_W-1:0] bank_mode;

    function automatic void flag(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: %s", msg);
    endfunction

    // Slot of a mode that banks only sp, lr and spsr; -1 if none
    function automatic int sp_lr_slot(logic [MODE_W-1:0] mode);
        case (mode)
            MODE_IRQ: return 0;
            MODE_SVC: return 1;
            MODE_ABT: return 2;
            MODE_UND: return 3;
            default:  return -1;
        endcase
    endfunction

    // Save the outgoing mode's copies, then load the incoming mode's
    function automatic void switch_mode_bank(logic [MODE_W-1:0] nm);
        logic [MODE_W-1:0] om;
        int s;
        om = bank_mode;
        if (om == nm) return;
        bank_mode = nm;

        if (om == MODE_USR || om == MODE_SYS) begin
            usr_sp_lr[0] = reg_view[R_SP];
            usr_sp_lr[1] = reg_view[R_LR];
        end else if (om == MODE_FIQ) begin
            for (int i = 0; i < 7; i++) fiq_save[i] = reg_view[R_BANK_LO + i];
            fiq_save[7] = spsr_now;
            for (int i = 0; i < 5; i++) reg_view[R_BANK_LO + i] = usr_hi[i];
        end else begin
            s = sp_lr_slot(om);
            if (s >= 0) begin
                mode_save[s][0] = reg_view[R_SP];
                mode_save[s][1] = reg_view[R_LR];
                mode_save[s][2] = spsr_now;
            end
        end

        if (nm == MODE_USR || nm == MODE_SYS) begin
            reg_view[R_SP] = usr_sp_lr[0];
            reg_view[R_LR] = usr_sp_lr[1];
        end else if (nm == MODE_FIQ) begin
            for (int i = 0; i < 5; i++) usr_hi[i] = reg_view[R_BANK_LO + i];
            for (int i = 0; i < 7; i++) reg_view[R_BANK_LO + i] = fiq_save[i];
            spsr_now = fiq_save[7];
        end else begin
            s = sp_lr_slot(nm);
            if (s >= 0) begin
                reg_view[R_SP] = mode_save[s][0];
                reg_view[R_LR] = mode_save[s][1];
                spsr_now = mode_save[s][2];
            end
        end
    endfunction

    function automatic void enter_exception(logic [KIND_W-1:0] kind);
        logic [WORD_W-1:0] old_cpsr;
        logic [WORD_W-1:0] ret_addr;
        logic [WORD_W-1:0] offs;
        logic [MODE_W-1:0] target;
        case (kind)
            EXC_RESET: begin offs = 32'h00; target = MODE_SVC; end
            EXC_UNDEF: begin offs = 32'h04; target = MODE_UND; end
            EXC_SWI:   begin offs = 32'h08; target = MODE_SVC; end
            EXC_PABT:  begin offs = 32'h0c; target = MODE_ABT; end
            EXC_DABT:  begin offs = 32'h10; target = MODE_ABT; end
            EXC_IRQ:   begin offs = 32'h18; target = MODE_IRQ; end
            EXC_FIQ:   begin offs = 32'h1c; target = MODE_FIQ; end
            default:   return;
        endcase
        old_cpsr = cpsr_now;
        if (kind == EXC_RESET) ret_addr = '0;
        else if (kind == EXC_DABT) ret_addr = reg_view[R_PC] + 32'd8;
        else ret_addr = reg_view[R_PC] + 32'd4;

        cpsr_now = (old_cpsr & ~(PSR_T | PSR_MODE)) | PSR_I | WORD_W'(target);
        switch_mode_bank(target);
        spsr_now = old_cpsr;
        reg_view[R_LR] = ret_addr;
        reg_view[R_PC] = vec_base + offs;
        if (kind == EXC_RESET || kind == EXC_FIQ) cpsr_now |= PSR_F;
    endfunction

    function automatic result_t apply_item(item_t it);
        result_t r;
        case (it.operation)
            OP_WRITE_REG:  reg_view[it.reg_index] = it.write_value;
            OP_WRITE_CPSR: begin
                cpsr_now = it.write_value;
                switch_mode_bank(it.write_value[MODE_W-1:0]);
            end
            OP_WRITE_SPSR: spsr_now = it.write_value;
            OP_EXCEPTION:  enter_exception(it.exception_kind);
            default: ;
        endcase
        r.read_data  = reg_view[it.reg_index];
        r.cpsr_value = cpsr_now;
        r.spsr_value = spsr_now;
        return r;
    endfunction

    // Input driver: one word at a time from pending_items, random gap after each while tx_idle is set
    always @(posedge aclk) begin : drv
        int unsigned g;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) due_results.push_back(apply_item(word_on_bus));
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (pending_items.size() != 0) begin
                    word_on_bus = pending_items.pop_front();
                    g = tx_idle ? $urandom_range(0, 5) : 0;
                    tx_gap <= g;
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, word_on_bus.write_value, word_on_bus.reg_index};
                    s_tuser <= {word_on_bus.exception_kind, word_on_bus.operation};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest expectation, random stalls while rx_idle is set
    always @(posedge aclk) begin : mon
        result_t want;
        int unsigned d;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold <= 0;
        end else if (m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                flag($sformatf("result word %h with nothing expected", m_tdata));
            end else begin
                want = due_results.pop_front();
                if (m_tdata[31:0] !== want.read_data)
                    flag($sformatf("read_data expected %h got %h", want.read_data,
                                   m_tdata[31:0]));
                if (m_tdata[63:32] !== want.cpsr_value)
                    flag($sformatf("cpsr_value expected %h got %h", want.cpsr_value,
                                   m_tdata[63:32]));
                if (m_tdata[95:64] !== want.spsr_value)
                    flag($sformatf("spsr_value expected %h got %h", want.spsr_value,
                                   m_tdata[95:64]));
            end
            d = rx_idle ? $urandom_range(0, 5) : 0;
            rx_hold <= d;
            m_tready <= (d == 0);
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void push(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                 logic [WORD_W-1:0] val, logic [KIND_W-1:0] kind);
        item_t it;
        it.operation = op;
        it.reg_index = idx;
        it.write_value = val;
        it.exception_kind = kind;
        pending_items.push_back(it);
    endfunction

    // Random word, weighted toward mode changes and banked registers
    function automatic void push_random();
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] val;
        logic [KIND_W-1:0] kind;
        int unsigned p;
        idx = ($urandom_range(0, 1) != 0) ? IDX_W'($urandom_range(R_BANK_LO, NREGS - 1))
                                         : IDX_W'($urandom_range(0, NREGS - 1));
        val = $urandom();
        if ($urandom_range(0, 9) == 0) val = {WORD_W{1'($urandom_range(0, 1))}};
        kind = KIND_W'($urandom_range(0, 7));
        p = $urandom_range(0, 99);
        if (p < 28) begin
            op = OP_READ_REG;
        end else if (p < 55) begin
            op = OP_WRITE_REG;
        end else if (p < 72) begin
            op = OP_WRITE_CPSR;
            // mostly defined modes, now and then an unknown one
            if ($urandom_range(0, 9) != 0) val[MODE_W-1:0] = MODE_LIST[$urandom_range(0, 6)];
        end else if (p < 80) begin
            op = OP_WRITE_SPSR;
        end else if (p < 95) begin
            op = OP_EXCEPTION;
        end else begin
            op = OP_W'($urandom_range(OP_EXCEPTION + 3'd1, OP_LAST));
        end
        push(op, idx, val, kind);
    endfunction

    // Let every word in flight come back before touching the config port
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || due_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write vector_base, then read it back
    task automatic set_vector_base(input logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= VBASE_ADDR; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        vec_base = v;
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== v) flag($sformatf("vector_base read expected %h got %h", v, prdata));
        psel <= 1'b0; penable <= 1'b0;
    endtask

    initial begin : stim
        logic [31:0] bases [5];
        for (int i = 0; i < NREGS; i++) reg_view[i] = '0;
        for (int i = 0; i < 8; i++) fiq_save[i] = '0;
        for (int i = 0; i < 4; i++) for (int j = 0; j < 3; j++) mode_save[i][j] = '0;
        usr_sp_lr = '{default: '0};
        usr_hi = '{default: '0};
        cpsr_now = CPSR_INIT;
        spsr_now = '0;
        bank_mode = MODE_SVC;
        vec_base = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, pc wrap, every exception, all modes, ignored codes
        push(OP_READ_REG,   4'd0,  32'h0,         EXC_NONE);
        push(OP_WRITE_REG,  4'd0,  32'hffff_ffff, EXC_RESET);
        push(OP_WRITE_REG,  4'd13, 32'h1313_1313, EXC_RESET);
        push(OP_WRITE_REG,  4'd14, 32'h1414_1414, EXC_RESET);
        push(OP_WRITE_SPSR, 4'd13, 32'hffff_ffff, EXC_RESET);
        push(OP_WRITE_REG,  4'd15, 32'hffff_fffc, EXC_RESET);
        push(OP_EXCEPTION,  4'd14, 32'h0,         EXC_DABT);
        push(OP_WRITE_REG,  4'd15, 32'hffff_fffc, EXC_RESET);
        push(OP_EXCEPTION,  4'd14, 32'h0,         EXC_UNDEF);
        push(OP_EXCEPTION,  4'd15, 32'h0,         EXC_SWI);
        push(OP_EXCEPTION,  4'd14, 32'h0,         EXC_PABT);
        push(OP_EXCEPTION,  4'd13, 32'h0,         EXC_IRQ);
        push(OP_WRITE_REG,  4'd8,  32'h8888_8888, EXC_RESET);
        push(OP_WRITE_REG,  4'd12, 32'hcccc_cccc, EXC_RESET);
        push(OP_EXCEPTION,  4'd8,  32'h0,         EXC_FIQ);
        push(OP_WRITE_REG,  4'd8,  32'h0,         EXC_RESET);
        push(OP_WRITE_CPSR, 4'd8,  32'h0000_0010, EXC_RESET);
        push(OP_WRITE_SPSR, 4'd12, 32'h5a5a_5a5a, EXC_RESET);
        push(OP_WRITE_CPSR, 4'd13, 32'hffff_ffff, EXC_RESET);
        push(OP_WRITE_CPSR, 4'd14, 32'h0000_0000, EXC_RESET);
        push(OP_WRITE_SPSR, 4'd14, 32'h0000_0001, EXC_RESET);
        push(OP_EXCEPTION,  4'd14, 32'h0,         EXC_RESET);
        push(OP_EXCEPTION,  4'd15, 32'hffff_ffff, EXC_NONE);
        push(OP_EXCEPTION + 3'd1, 4'd15, 32'hffff_ffff, EXC_FIQ);
        push(OP_LAST,       4'd0,  32'hffff_ffff, EXC_NONE);
        push(OP_WRITE_CPSR, 4'd14, 32'h0000_001b, EXC_RESET);
        drain();

        // Random phases, each under its own vector base
        bases = '{32'hffff_ffe4, 32'h0000_0000, 32'hffff_ffff, $urandom(), $urandom()};
        for (int ph = 0; ph < 5; ph++) begin
            set_vector_base(bases[ph]);
            tx_idle = (ph != 1);
            rx_idle = (ph != 1) && (ph != 3);
            for (int n = 0; n < PHASE_WORDS; n++) push_random();
            drain();
        end

        if (err_cnt == 0 && due_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
